// ===== sv/spq_pkg.sv =====
// types and codes shared by the sorted priority queue cells and top level
// no dependencies

package spq_pkg;

  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int CNT_OUT_W = 5;

  // request kinds carried in s_tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// result: a result word is registered and appears in the cycle after its request word is taken
// throughput: one request per cycle while the output register is free; every cell of the row
//   compares against the new key and updates in the same cycle, so no request waits on another
// reset: clears the entry count and the output valid flag; result fields and cells are left as is
// stalls: s_tready follows the output register, which frees when m_tready is high

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // new_key[31:0], new_payload[63:32]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_key[31:0], out_payload[63:32], entry_count[68:64]
  output logic [1:0]  m_tuser    // status
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic               accept;
  logic               full;
  logic               empty;
  cell_ctl_t          ctl;
  entry_t             new_entry;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   keep;
  entry_t             cells [DEPTH];
  status_t            status_next;

  logic                    out_valid;
  status_t                 out_status;
  logic signed [KEY_W-1:0] out_key;
  logic [PAY_W-1:0]        out_payload;
  logic [CNT_OUT_W-1:0]    out_count;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  assign new_entry.key     = $signed(s_tdata[31:0]);
  assign new_entry.payload = s_tdata[63:32];

  assign ctl.ins = accept && (s_tuser == REQ_INSERT) && !full;
  assign ctl.del = accept && (s_tuser == REQ_DELETE) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count);
      if (i == 0) begin : g_head
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .new_entry   (new_entry),
          .occupied    (occ[i]),
          .left_keep   (1'b1),
          .left_entry  (new_entry),
          .right_entry (cells[i+1]),
          .keep        (keep[i]),
          .entry       (cells[i])
        );
      end else if (i == DEPTH - 1) begin : g_tail
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .new_entry   (new_entry),
          .occupied    (occ[i]),
          .left_keep   (keep[i-1]),
          .left_entry  (cells[i-1]),
          .right_entry (new_entry),
          .keep        (keep[i]),
          .entry       (cells[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .ctl         (ctl),
          .new_entry   (new_entry),
          .occupied    (occ[i]),
          .left_keep   (keep[i-1]),
          .left_entry  (cells[i-1]),
          .right_entry (cells[i+1]),
          .keep        (keep[i]),
          .entry       (cells[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    status_next = STAT_OK;
    if (s_tuser == REQ_INSERT && full) begin
      status_next = STAT_FULL;
    end else if (s_tuser == REQ_DELETE && empty) begin
      status_next = STAT_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status  <= status_next;
      out_key     <= ctl.del ? cells[0].key : '0;
      out_payload <= ctl.del ? cells[0].payload : '0;
      out_count   <= CNT_OUT_W'(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {3'b000, out_count, out_payload, out_key};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == REQ_INSERT && full |=> m_tuser == STAT_FULL && $stable(count))
    else $error("insert on full queue not refused");

  a_empty_refused: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == REQ_DELETE && empty |=> m_tuser == STAT_EMPTY && count == '0)
    else $error("delete on empty queue not refused");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    ctl.del |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not lower the count");

  a_ctl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.del))
    else $error("insert and delete at once");

endmodule

// ===== sv/spq_cell.sv =====
// one slot of the sorted register row: holds an entry, decides keep/take/shift
// depends on spq_pkg

module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   new_entry,
  input  logic              occupied,
  input  logic              left_keep,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output logic              keep,
  output spq_pkg::entry_t   entry
);
  import spq_pkg::*;

  entry_t entry_next;

  // on an insert, a slot stays put when it holds a key strictly below the new one
  assign keep = occupied && (entry.key < new_entry.key);

  always_comb begin
    entry_next = entry;
    if (ctl.del) begin
      entry_next = right_entry;
    end else if (ctl.ins && !keep) begin
      // first slot that does not keep takes the new word, the rest shift up
      if (left_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
